// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [7:0]  CheckInit = 8'hFF;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_START  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACK    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NAK    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CANCEL = 2'd3;

  localparam logic [7:0] RstStartCode  = 8'd1;
  localparam logic [7:0] RstAckCode    = 8'd6;
  localparam logic [7:0] RstNakCode    = 8'd21;
  localparam logic [7:0] RstCancelCode = 8'd24;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic [7:0] cancel_code;
  } cfg_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       frame_end;
    logic       frame_good;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       start_send;
    logic       pop_head;
    logic       start_while_waiting;
    logic       stray_byte;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Control code registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [sfr_pkg::CfgIdxW-1:0] index,
  input  wire logic [7:0]                  wdata,
  output sfr_pkg::cfg_t                    cfg
);

  sfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= sfr_pkg::RstStartCode;
      cfg_r.ack_code    <= sfr_pkg::RstAckCode;
      cfg_r.nak_code    <= sfr_pkg::RstNakCode;
      cfg_r.cancel_code <= sfr_pkg::RstCancelCode;
    end else if (wr_en) begin
      unique case (index)
        sfr_pkg::CFG_START:  cfg_r.start_code  <= wdata;
        sfr_pkg::CFG_ACK:    cfg_r.ack_code    <= wdata;
        sfr_pkg::CFG_NAK:    cfg_r.nak_code    <= wdata;
        sfr_pkg::CFG_CANCEL: cfg_r.cancel_code <= wdata;
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/sfr_rx_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_rx_ctrl
// Frame phase, length count, running XOR check and acknowledgement tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_rx_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic       command,
  input  wire logic [7:0] rx_byte,
  input  wire logic       queue_has_frame,
  input  wire sfr_pkg::cfg_t cfg,
  output sfr_pkg::result_t res
);

  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      left_r, left_nxt;
  logic [7:0]      check_r, check_nxt;
  logic            await_r, await_nxt;
  sfr_pkg::result_t res_c;

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    check_nxt = check_r;
    await_nxt = await_r;
    res_c     = '0;

    if (command == sfr_pkg::CMD_TICK) begin
      unique case (phase_r)
        sfr_pkg::PH_LEN, sfr_pkg::PH_BODY: begin
          // abort mid-frame
          res_c.frame_end   = 1'b1;
          res_c.reply_valid = 1'b1;
          res_c.reply_byte  = cfg.nak_code;
          phase_nxt         = sfr_pkg::PH_IDLE;
          left_nxt          = '0;
        end
        default: begin
          phase_nxt = sfr_pkg::PH_IDLE;
          if (queue_has_frame && !await_r) begin
            res_c.start_send = 1'b1;
            await_nxt        = 1'b1;
          end
        end
      endcase
    end else begin
      unique case (phase_r)
        sfr_pkg::PH_LEN: begin
          check_nxt = check_r ^ rx_byte;
          if (rx_byte == 8'd0) begin
            res_c.frame_end   = 1'b1;
            res_c.reply_valid = 1'b1;
            res_c.reply_byte  = cfg.nak_code;
            phase_nxt         = sfr_pkg::PH_IDLE;
            left_nxt          = '0;
          end else begin
            left_nxt  = rx_byte;
            phase_nxt = sfr_pkg::PH_BODY;
          end
        end
        sfr_pkg::PH_BODY: begin
          if (left_r > 8'd1) begin
            res_c.body_valid = 1'b1;
            res_c.body_byte  = rx_byte;
            check_nxt        = check_r ^ rx_byte;
            left_nxt         = left_r - 8'd1;
          end else begin
            res_c.frame_end   = 1'b1;
            res_c.frame_good  = (rx_byte == check_r);
            res_c.reply_valid = 1'b1;
            res_c.reply_byte  = (rx_byte == check_r) ? cfg.ack_code : cfg.nak_code;
            phase_nxt         = sfr_pkg::PH_IDLE;
            left_nxt          = '0;
          end
        end
        default: begin
          phase_nxt = sfr_pkg::PH_IDLE;
          // order decides where codes coincide
          priority if (rx_byte == cfg.start_code) begin
            res_c.start_while_waiting = await_r;
            await_nxt = 1'b0;
            phase_nxt = sfr_pkg::PH_LEN;
            check_nxt = sfr_pkg::CheckInit;
            left_nxt  = '0;
          end else if (rx_byte == cfg.cancel_code || rx_byte == cfg.nak_code) begin
            await_nxt = 1'b0;
          end else if (rx_byte == cfg.ack_code) begin
            res_c.pop_head = await_r;
            await_nxt      = 1'b0;
          end else begin
            res_c.stray_byte = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfr_pkg::PH_IDLE;
      left_r  <= '0;
      check_r <= sfr_pkg::CheckInit;
      await_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      check_r <= check_nxt;
      await_r <= await_nxt;
    end
  end

  assign res = res_c;

  a_pop_clears_await: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_c.pop_head |=> !await_r)
    else $error("acknowledged head but still awaiting");

  a_send_sets_await: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_c.start_send |=> await_r && phase_r == sfr_pkg::PH_IDLE)
    else $error("send started without awaiting acknowledgement");

  a_body_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_c.body_valid |-> phase_r == sfr_pkg::PH_BODY && left_r > 8'd1)
    else $error("body byte outside a frame body");

  a_end_replies: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_c.frame_end |=> phase_r == sfr_pkg::PH_IDLE && left_r == 8'd0)
    else $error("frame end left the receiver inside a frame");

endmodule

`default_nettype wire

// File: rtl/sfr_out_buf.sv
// ----------------------------------------------------------------------------
// sfr_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_buf (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire sfr_pkg::result_t in_res,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sfr_pkg::result_t out_res
);

  logic             out_valid_r, skid_valid_r;
  sfr_pkg::result_t out_res_r, skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_res_r <= skid_valid_r ? skid_res_r : in_res;
    end else if (in_fire) begin
      skid_res_r <= in_res;
    end
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

endmodule

`default_nettype wire

// File: rtl/serial_frame_receiver_with_ack_core.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_ack_core
// Link-layer receiver for start/length/XOR-check frames with ACK/NAK reply.
// ----------------------------------------------------------------------------
// One item (a received byte or an idle tick) is taken per clock cycle while
// in_tready is high, and its result is registered in the output register or
// the skid entry. Phase, count and check advance together on each accepted
// item; the result side has a two-entry buffer, and in_tready falls only when
// both entries are full, being driven from a register. Control codes may be
// rewritten on the cfg port while no item is in flight.
`default_nettype none

module serial_frame_receiver_with_ack_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [15:0]                 in_tdata,  // rx_byte[7:0], queue_has_frame[8]
  input  wire logic                        in_tuser,  // command
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [23:0]                      out_tdata, // body_byte[7:0], frame_good[8],
                                                      // reply_byte[16:9], start_send[17],
                                                      // pop_head[18],
                                                      // start_while_waiting[19],
                                                      // stray_byte[20]
  output logic [1:0]                       out_tuser, // body_valid[0], reply_valid[1]
  output logic                             out_tlast, // frame_end
  input  wire logic                        cfg_wr_en,
  input  wire logic [sfr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]                  cfg_wdata
);

  sfr_pkg::cfg_t    cfg;
  sfr_pkg::result_t step_res, out_res;
  logic             in_fire;

  assign in_fire = in_tvalid && in_tready;

  sfr_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  sfr_rx_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .command         (in_tuser),
    .rx_byte         (in_tdata[7:0]),
    .queue_has_frame (in_tdata[8]),
    .cfg             (cfg),
    .res             (step_res)
  );

  sfr_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_res    (step_res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'b000, out_res.stray_byte, out_res.start_while_waiting,
                      out_res.pop_head, out_res.start_send, out_res.reply_byte,
                      out_res.frame_good, out_res.body_byte};
  assign out_tuser = {out_res.reply_valid, out_res.body_valid};
  assign out_tlast = out_res.frame_end;

endmodule

`default_nettype wire
